/* hw/rtl/aes128_cbc_cipher_macros.svh */
// ----------------------------------------------------------------------------
// aes128_cbc_cipher_macros
// assertion macros shared by the cipher rtl
// ----------------------------------------------------------------------------
`ifndef AES128_CBC_CIPHER_MACROS_SVH
`define AES128_CBC_CIPHER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AES_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AES_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define AES_ASSERT(label, clk, rst_n, prop, msg)
`define AES_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

/* hw/rtl/aes_cbc_pkg.sv */
// ----------------------------------------------------------------------------
// aes_cbc_pkg
// shared types, constants and round functions for the aes-128 cbc cipher
// ----------------------------------------------------------------------------
package aes_cbc_pkg;

	localparam int ROUND_COUNT = 10;
	localparam int RK_WORDS    = 2 * (ROUND_COUNT + 1);
	localparam int RK_AW       = $clog2(RK_WORDS);
	localparam int RND_W       = $clog2(ROUND_COUNT + 1);

	localparam logic [2:0] CFG_KEY_HIGH = 3'd0;
	localparam logic [2:0] CFG_KEY_LOW  = 3'd1;
	localparam logic [2:0] CFG_IV_HIGH  = 3'd2;
	localparam logic [2:0] CFG_IV_LOW   = 3'd3;
	localparam logic [2:0] CFG_DECRYPT  = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_LOAD,
		ST_ROUND,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       expand_start;
		logic       expand_step;
		logic       load;
		logic       round_step;
		logic       finish;
		logic [RND_W-1:0] round;
		logic       rk_rd;
	} ctrl_cmd_t;

	typedef struct packed {
		logic decrypt;
	} ctrl_sts_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// byte i of the state sits at bits [127-8i -: 8]
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[127 - 8 * (c * 4 + r) -: 8] = SBOX[s[127 - 8 * (((c + r) % 4) * 4 + r) -: 8]];
		return t;
	endfunction

	function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
		logic [127:0] t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[127 - 8 * (((c + r) % 4) * 4 + r) -: 8] = INV_SBOX[s[127 - 8 * (c * 4 + r) -: 8]];
		return t;
	endfunction

	function automatic logic [127:0] mix(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127 - 32 * c -: 8];
			a1 = s[119 - 32 * c -: 8];
			a2 = s[111 - 32 * c -: 8];
			a3 = s[103 - 32 * c -: 8];
			t[127 - 32 * c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
			t[119 - 32 * c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
			t[111 - 32 * c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
			t[103 - 32 * c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
		end
		return t;
	endfunction

	function automatic logic [127:0] inv_mix(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a [4];
		logic [7:0] u, v;
		for (int c = 0; c < 4; c++) begin
			for (int j = 0; j < 4; j++)
				a[j] = s[127 - 32 * c - 8 * j -: 8];
			// preprocess to forward mix form
			u = xt(xt(a[0] ^ a[2]));
			v = xt(xt(a[1] ^ a[3]));
			a[0] = a[0] ^ u;
			a[1] = a[1] ^ v;
			a[2] = a[2] ^ u;
			a[3] = a[3] ^ v;
			for (int j = 0; j < 4; j++)
				t[127 - 32 * c - 8 * j -: 8] = a[j];
		end
		return mix(t);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

endpackage

/* hw/rtl/aes_cbc_ram.sv */
// ----------------------------------------------------------------------------
// aes_cbc_ram
// generic single-port write, single-port read ram with registered read
// ----------------------------------------------------------------------------
module aes_cbc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 22
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

/* hw/rtl/aes_cbc_datapath.sv */
// ----------------------------------------------------------------------------
// aes_cbc_datapath
// config registers, key expansion, round key store, round unit and chain
// ----------------------------------------------------------------------------
`include "aes128_cbc_cipher_macros.svh"
module aes_cbc_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic [2:0]             cfg_index,
	input  logic [63:0]            cfg_data,
	input  logic                   in_take,
	input  logic [63:0]            block_high,
	input  logic [63:0]            block_low,
	input  aes_cbc_pkg::ctrl_cmd_t cmd,
	output aes_cbc_pkg::ctrl_sts_t sts,
	output logic [63:0]            out_high,
	output logic [63:0]            out_low
);
	logic [63:0]  key_high_q, key_low_q, iv_high_q, iv_low_q;
	logic         decrypt_q;
	logic [127:0] chain_q, blk_q, state_q, kexp_q, res_q;
	logic [7:0]   rcon_q;
	logic         wr_hi_q;
	logic [aes_cbc_pkg::RK_AW-1:0] wr_addr_q, rd_addr;
	logic [63:0]  wr_data, rd_data;
	logic         wr_en;
	logic [63:0]  rk_hi_q;
	logic [127:0] rk, kexp_next, step;
	logic [31:0]  t, w0, w1, w2, w3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			iv_high_q  <= '0;
			iv_low_q   <= '0;
			decrypt_q  <= 1'b0;
			chain_q    <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					aes_cbc_pkg::CFG_KEY_HIGH: key_high_q <= cfg_data;
					aes_cbc_pkg::CFG_KEY_LOW:  key_low_q  <= cfg_data;
					aes_cbc_pkg::CFG_IV_HIGH:  iv_high_q  <= cfg_data;
					aes_cbc_pkg::CFG_IV_LOW:   iv_low_q   <= cfg_data;
					aes_cbc_pkg::CFG_DECRYPT:  decrypt_q  <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.expand_start) begin
				chain_q <= {iv_high_q, iv_low_q};
			end else if (cmd.finish) begin
				chain_q <= decrypt_q ? blk_q : step;
			end
		end
	end

	// key expansion, one round key per two ram writes (high then low word)
	always_comb begin
		t  = aes_cbc_pkg::sub_word({kexp_q[23:0], kexp_q[31:24]}) ^ {rcon_q, 24'h0};
		w0 = kexp_q[127:96] ^ t;
		w1 = kexp_q[95:64] ^ w0;
		w2 = kexp_q[63:32] ^ w1;
		w3 = kexp_q[31:0] ^ w2;
		kexp_next = {w0, w1, w2, w3};
	end

	always_ff @(posedge clk) begin
		if (cmd.expand_start) begin
			kexp_q    <= {key_high_q, key_low_q};
			rcon_q    <= 8'h01;
			wr_hi_q   <= 1'b1;
			wr_addr_q <= '0;
		end else if (cmd.expand_step) begin
			wr_hi_q   <= ~wr_hi_q;
			wr_addr_q <= wr_addr_q + aes_cbc_pkg::RK_AW'(1);
			if (!wr_hi_q) begin
				kexp_q <= kexp_next;
				rcon_q <= aes_cbc_pkg::xt(rcon_q);
			end
		end
	end

	assign wr_en   = cmd.expand_step;
	assign wr_data = wr_hi_q ? kexp_q[127:64] : kexp_q[63:0];
	assign rd_addr = {cmd.round, cmd.rk_rd};

	aes_cbc_ram #(.WIDTH(64), .DEPTH(aes_cbc_pkg::RK_WORDS)) u_rk_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr_q),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// round key assembled from the registered high word and the low word now read
	always_ff @(posedge clk) begin
		rk_hi_q <= rd_data;
	end
	assign rk = {rk_hi_q, rd_data};

	always_comb begin
		step = state_q ^ rk;
		if (cmd.round_step) begin
			if (!decrypt_q) begin
				if (cmd.finish)
					step = aes_cbc_pkg::sub_shift(state_q) ^ rk;
				else
					step = aes_cbc_pkg::mix(aes_cbc_pkg::sub_shift(state_q)) ^ rk;
			end else begin
				if (cmd.finish)
					step = aes_cbc_pkg::inv_sub_shift(state_q) ^ rk ^ chain_q;
				else
					step = aes_cbc_pkg::inv_mix(aes_cbc_pkg::inv_sub_shift(state_q) ^ rk);
			end
		end else if (!decrypt_q) begin
			step = state_q ^ chain_q ^ rk;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			blk_q   <= {block_high, block_low};
			state_q <= {block_high, block_low};
		end else if (cmd.load || cmd.round_step) begin
			state_q <= step;
		end
		if (cmd.finish) begin
			res_q <= step;
		end
	end

	assign out_high    = res_q[127:64];
	assign out_low     = res_q[63:0];
	assign sts.decrypt = decrypt_q;

	`AES_ASSERT_NEVER(a_no_wr_rd_overlap, clk, arst_n, wr_en && cmd.round_step,
		"round step during key expansion")
	`AES_ASSERT(a_chain_enc, clk, arst_n,
		(cmd.finish && !decrypt_q && !cmd.expand_start) |=> (chain_q == res_q),
		"encrypt chain differs from result")
	`AES_ASSERT(a_iv_load, clk, arst_n,
		cmd.expand_start |=> (chain_q == $past({iv_high_q, iv_low_q})),
		"chain not loaded from iv")
endmodule

/* hw/rtl/aes_cbc_ctrl.sv */
// ----------------------------------------------------------------------------
// aes_cbc_ctrl
// sequencer for key expansion, round iteration and result handshake
// ----------------------------------------------------------------------------
`include "aes128_cbc_cipher_macros.svh"
module aes_cbc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   first_block,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   in_take,
	input  aes_cbc_pkg::ctrl_sts_t sts,
	output aes_cbc_pkg::ctrl_cmd_t cmd
);
	localparam int EXP_STEPS = aes_cbc_pkg::RK_WORDS;
	localparam int CW = $clog2(EXP_STEPS + 1);

	aes_cbc_pkg::state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          out_valid_q, out_valid_d;
	logic [aes_cbc_pkg::RND_W-1:0] first_rnd, last_rnd, rnd_q, rnd_d;

	assign first_rnd = sts.decrypt ? aes_cbc_pkg::RND_W'(aes_cbc_pkg::ROUND_COUNT) : '0;
	assign last_rnd  = sts.decrypt ? '0 : aes_cbc_pkg::RND_W'(aes_cbc_pkg::ROUND_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aes_cbc_pkg::ST_IDLE;
			cnt_q       <= '0;
			rnd_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			rnd_q       <= rnd_d;
			out_valid_q <= out_valid_d;
		end
	end

	// results wait in the output register; the next block starts behind it
	// and holds at its last round until the waiting result is taken
	assign in_ready  = (state_q == aes_cbc_pkg::ST_IDLE);
	assign in_take   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		rnd_d       = rnd_q;
		out_valid_d = out_valid_q && !out_ready;
		cmd         = '0;
		cmd.round   = rnd_q;
		case (state_q)
			aes_cbc_pkg::ST_IDLE: begin
				if (in_take) begin
					cmd.expand_start = first_block;
					cnt_d   = '0;
					rnd_d   = first_rnd;
					state_d = first_block ? aes_cbc_pkg::ST_EXPAND : aes_cbc_pkg::ST_LOAD;
				end
			end
			aes_cbc_pkg::ST_EXPAND: begin
				cmd.expand_step = 1'b1;
				cnt_d = cnt_q + CW'(1);
				if (cnt_q == CW'(EXP_STEPS - 1)) begin
					cnt_d   = '0;
					rnd_d   = first_rnd;
					state_d = aes_cbc_pkg::ST_LOAD;
				end
			end
			aes_cbc_pkg::ST_LOAD: begin
				// read high then low word of the round key
				cmd.rk_rd = cnt_q[0];
				cnt_d = cnt_q + CW'(1);
				if (cnt_q == CW'(2)) begin
					cmd.rk_rd = 1'b1;
					cmd.load  = 1'b1;
					cnt_d     = '0;
					rnd_d     = sts.decrypt ? rnd_q - aes_cbc_pkg::RND_W'(1)
						: rnd_q + aes_cbc_pkg::RND_W'(1);
					cmd.round = rnd_d;
					state_d   = aes_cbc_pkg::ST_ROUND;
				end
			end
			aes_cbc_pkg::ST_ROUND: begin
				cmd.rk_rd = cnt_q[0];
				if (rnd_q == last_rnd && cnt_q == '0 && out_valid_q && !out_ready) begin
					// last round waits on the high word read
					cnt_d = cnt_q;
				end else begin
					cnt_d = cnt_q + CW'(1);
					if (cnt_q == CW'(2)) begin
						cmd.rk_rd      = 1'b1;
						cmd.round_step = 1'b1;
						cnt_d          = '0;
						if (rnd_q == last_rnd) begin
							cmd.finish  = 1'b1;
							out_valid_d = 1'b1;
							state_d     = aes_cbc_pkg::ST_IDLE;
						end else begin
							rnd_d     = sts.decrypt ? rnd_q - aes_cbc_pkg::RND_W'(1)
								: rnd_q + aes_cbc_pkg::RND_W'(1);
							cmd.round = rnd_d;
						end
					end
				end
			end
			default: state_d = aes_cbc_pkg::ST_IDLE;
		endcase
	end

	`AES_ASSERT_NEVER(a_take_busy, clk, arst_n,
		in_take && state_q != aes_cbc_pkg::ST_IDLE, "input taken while busy")
	`AES_ASSERT(a_finish_valid, clk, arst_n, cmd.finish |=> out_valid,
		"finished block not presented")
	`AES_ASSERT_NEVER(a_finish_full, clk, arst_n, cmd.finish && out_valid && !out_ready,
		"result overwritten before taken")
endmodule

/* hw/rtl/aes128_cbc_cipher.sv */
// key expansion runs on first_block, ahead of the rounds
// one round per three round-key ram reads; no new block is taken before the last ends its rounds
// the round key ram is 64 bits wide, so each round key takes two reads plus a register stage
// a result not yet taken holds the next block at its last round
// reset: asynchronous active low, clears config, chain and control; key ram and round data undefined
// ----------------------------------------------------------------------------
// aes128_cbc_cipher
// aes-128 cbc encrypt and decrypt, iterative single round unit
// ----------------------------------------------------------------------------
module aes128_cbc_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	input  logic        first_block,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] out_high,
	output logic [63:0] out_low
);
	aes_cbc_pkg::ctrl_cmd_t cmd;
	aes_cbc_pkg::ctrl_sts_t sts;
	logic in_take;

	assign cfg_ready = 1'b1;

	aes_cbc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.first_block (first_block),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.in_take     (in_take),
		.sts         (sts),
		.cmd         (cmd)
	);

	aes_cbc_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_take    (in_take),
		.block_high (block_high),
		.block_low  (block_low),
		.cmd        (cmd),
		.sts        (sts),
		.out_high   (out_high),
		.out_low    (out_low)
	);
endmodule

/* tb/sv/tb_aes128_cbc_cipher.sv */
// ----------------------------------------------------------------------------
// tb_aes128_cbc_cipher
// drives blocks through the aes-128 cbc cipher, predicts each result with an
// independent aes/cbc calculation and compares it with the monitored output
// ----------------------------------------------------------------------------
module tb_aes128_cbc_cipher;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
		logic        first;
	} blk_t;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
	} res_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [63:0] block_high = '0;
	logic [63:0] block_low = '0;
	logic        first_block = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [63:0] out_high;
	logic [63:0] out_low;

	aes128_cbc_cipher u_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	blk_t pending_blocks[$];
	res_t expected_blocks[$];
	logic [7:0] sb [256];
	logic [7:0] isb [256];
	logic [127:0] key_reg, iv_reg, chain;
	logic         dec_reg;
	logic [127:0] rk [11];
	int errors = 0;
	int idle_cycles = 0;
	bit calm = 0;
	bit hold_req = 0;
	int hold_cnt = 0;
	int in_gap = 0, out_gap = 0;

	function automatic logic [7:0] gx(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gm(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = gx(a);
		end
		return p;
	endfunction

	function automatic logic [7:0] byt(input logic [127:0] s, input int i);
		return s[127 - 8 * i -: 8];
	endfunction

	task automatic expand_round_keys();
		logic [31:0] w [44];
		logic [31:0] t;
		logic [7:0] rc;
		rc = 8'h01;
		for (int i = 0; i < 4; i++) w[i] = key_reg[127 - 32 * i -: 32];
		for (int i = 4; i < 44; i++) begin
			t = w[i - 1];
			if (i % 4 == 0) begin
				t = {t[23:0], t[31:24]};
				t = {sb[t[31:24]], sb[t[23:16]], sb[t[15:8]], sb[t[7:0]]};
				t ^= {rc, 24'h0};
				rc = gx(rc);
			end
			w[i] = w[i - 4] ^ t;
		end
		for (int r = 0; r < 11; r++) rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
	endtask

	function automatic logic [127:0] subshift(input logic [127:0] s, input bit inv);
		logic [127:0] t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				if (inv)
					t[127 - 8 * (((c + r) % 4) * 4 + r) -: 8] = isb[byt(s, c * 4 + r)];
				else
					t[127 - 8 * (c * 4 + r) -: 8] = sb[byt(s, ((c + r) % 4) * 4 + r)];
		return t;
	endfunction

	function automatic logic [127:0] mixcols(input logic [127:0] s, input bit inv);
		logic [7:0] m [4];
		logic [127:0] t;
		logic [7:0] b;
		if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
		else m = '{8'd2, 8'd3, 8'd1, 8'd1};
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				b = 0;
				for (int j = 0; j < 4; j++) b ^= gm(byt(s, 4 * c + j), m[(j - r + 4) % 4]);
				t[127 - 8 * (4 * c + r) -: 8] = b;
			end
		return t;
	endfunction

	task automatic predict_block(input blk_t b);
		logic [127:0] s, blk;
		res_t e;
		blk = {b.hi, b.lo};
		if (b.first) begin
			chain = iv_reg;
			expand_round_keys();
		end
		if (dec_reg) begin
			s = blk ^ rk[10];
			for (int r = 9; r >= 1; r--) s = mixcols(subshift(s, 1) ^ rk[r], 1);
			s = subshift(s, 1) ^ rk[0] ^ chain;
			chain = blk;
		end else begin
			s = blk ^ chain ^ rk[0];
			for (int r = 1; r < 10; r++) s = mixcols(subshift(s, 0), 0) ^ rk[r];
			s = subshift(s, 0) ^ rk[10];
			chain = s;
		end
		e.hi = s[127:64];
		e.lo = s[63:0];
		expected_blocks.push_back(e);
	endtask

	// driver
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			predict_block(pending_blocks.pop_front());
		end
		if (!in_valid || in_ready) begin
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 0;
			end else if (pending_blocks.size() != 0) begin
				in_valid <= 1;
				block_high <= pending_blocks[0].hi;
				block_low <= pending_blocks[0].lo;
				first_block <= pending_blocks[0].first;
				if (!calm && $urandom_range(0, 7) == 0) in_gap <= $urandom_range(1, 11);
			end else begin
				in_valid <= 0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		res_t e;
		if (out_valid && out_ready) begin
			if (expected_blocks.size() == 0) begin
				$error("result transaction with nothing expected");
				errors++;
			end else begin
				e = expected_blocks.pop_front();
				if (out_high !== e.hi) begin
					$error("out_high expected %h actual %h", e.hi, out_high);
					errors++;
				end
				if (out_low !== e.lo) begin
					$error("out_low expected %h actual %h", e.lo, out_low);
					errors++;
				end
			end
		end
		if (hold_req) begin
			hold_cnt <= 400;
			out_ready <= 0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ready <= 0;
		end else if (out_gap > 0) begin
			out_gap <= out_gap - 1;
			out_ready <= 0;
		end else begin
			out_ready <= 1;
			if (!calm && $urandom_range(0, 7) == 0) out_gap <= $urandom_range(1, 11);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("aes128_cbc_cipher test failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			aes_cbc_pkg::CFG_KEY_HIGH: key_reg[127:64] = val;
			aes_cbc_pkg::CFG_KEY_LOW:  key_reg[63:0] = val;
			aes_cbc_pkg::CFG_IV_HIGH:  iv_reg[127:64] = val;
			aes_cbc_pkg::CFG_IV_LOW:   iv_reg[63:0] = val;
			aes_cbc_pkg::CFG_DECRYPT:  dec_reg = val[0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_blocks.size() != 0 || expected_blocks.size() != 0 || in_valid)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic push_block(input logic [63:0] h, input logic [63:0] l, input logic f);
		blk_t b;
		b.hi = h;
		b.lo = l;
		b.first = f;
		pending_blocks.push_back(b);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] edge64();
		case ($urandom_range(0, 5))
			0: return 64'h0;
			1: return '1;
			default: return rnd64();
		endcase
	endfunction

	initial begin
		logic [63:0] ins [2];
		int sent, n;
		for (int i = 0; i < 256; i++) sb[i] = aes_cbc_pkg::SBOX[i];
		for (int i = 0; i < 256; i++) isb[sb[i]] = 8'(i);
		key_reg = '0;
		iv_reg = '0;
		chain = '0;
		dec_reg = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		// standard vector key, iv and blocks, then all-zero and all-one blocks and a new first block
		write_reg(aes_cbc_pkg::CFG_KEY_HIGH, 64'h2b7e151628aed2a6);
		write_reg(aes_cbc_pkg::CFG_KEY_LOW, 64'habf7158809cf4f3c);
		write_reg(aes_cbc_pkg::CFG_IV_HIGH, 64'h0001020304050607);
		write_reg(aes_cbc_pkg::CFG_IV_LOW, 64'h08090a0b0c0d0e0f);
		write_reg(aes_cbc_pkg::CFG_DECRYPT, 64'h0);
		push_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 1'b1);
		push_block(64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 1'b0);
		push_block(64'h0, 64'h0, 1'b0);
		push_block('1, '1, 1'b0);
		push_block(64'h0, '1, 1'b1);
		drain();
		// key and iv changed mid-message have no effect until next first block
		write_reg(aes_cbc_pkg::CFG_KEY_HIGH, '1);
		write_reg(aes_cbc_pkg::CFG_IV_LOW, '1);
		push_block(64'h1234, 64'h5678, 1'b0);
		push_block('1, 64'h0, 1'b0);
		drain();
		// mode changed mid-message
		write_reg(aes_cbc_pkg::CFG_DECRYPT, 64'h1);
		push_block(64'h7649abac8119b246, 64'hcee98e9b12e9197d, 1'b0);
		push_block('1, '1, 1'b1);
		push_block(64'h0, 64'h0, 1'b0);
		drain();
		write_reg(aes_cbc_pkg::CFG_KEY_LOW, '1);
		write_reg(aes_cbc_pkg::CFG_IV_HIGH, '1);
		write_reg(aes_cbc_pkg::CFG_DECRYPT, 64'h0);
		push_block(64'h0, 64'h0, 1'b1);
		push_block('1, '1, 1'b0);
		drain();
		write_reg(aes_cbc_pkg::CFG_KEY_HIGH, 64'h0);
		write_reg(aes_cbc_pkg::CFG_KEY_LOW, 64'h0);
		write_reg(aes_cbc_pkg::CFG_IV_HIGH, 64'h0);
		write_reg(aes_cbc_pkg::CFG_IV_LOW, 64'h0);
		push_block(64'h0, 64'h0, 1'b1);
		push_block(64'h0, 64'h0, 1'b0);
		drain();
		// backpressure: receiver holds off while the sender keeps offering
		for (int i = 0; i < 12; i++) push_block(rnd64(), rnd64(), i == 0);
		@(posedge clk);
		hold_req <= 1;
		@(posedge clk);
		hold_req <= 0;
		drain();
		// random messages, settings changed between phases
		sent = 0;
		while (sent < 1400) begin
			if (sent > 1200) calm = 1;
			for (int r = 0; r < 5; r++)
				if ($urandom_range(0, 2) == 0 || r == 4)
					write_reg(r[2:0], r == 4 ? {63'h0, 1'($urandom)} : edge64());
			n = $urandom_range(5, 40);
			for (int i = 0; i < n; i++) begin
				ins[0] = ($urandom_range(0, 15) == 0) ? edge64() : rnd64();
				ins[1] = ($urandom_range(0, 15) == 0) ? edge64() : rnd64();
				push_block(ins[0], ins[1], i == 0 || $urandom_range(0, 19) == 0);
			end
			sent += n;
			drain();
		end
		if (errors == 0)
			$display("aes128_cbc_cipher test passed");
		else
			$display("aes128_cbc_cipher test failed");
		$finish;
	end
endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/aes_cbc_pkg.sv
hw/rtl/aes_cbc_ram.sv
hw/rtl/aes_cbc_datapath.sv
hw/rtl/aes_cbc_ctrl.sv
hw/rtl/aes128_cbc_cipher.sv
tb/sv/tb_aes128_cbc_cipher.sv
